/* src/y86ie_pkg.sv */
// Package for the Y86-64 instruction executor: status codes, instruction codes,
// queue entry type, back end states and helper functions. No dependencies.
`default_nettype none
package y86ie_pkg;

   localparam int MemBytesDefault = 4096;
   localparam logic [3:0] NoReg = 4'hF;
   localparam logic [3:0] SpReg = 4'h4;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_HLT = 2'd1,
      ST_ADR = 2'd2,
      ST_INS = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      I_HALT   = 4'h0,
      I_NOP    = 4'h1,
      I_RRMOVQ = 4'h2,
      I_IRMOVQ = 4'h3,
      I_RMMOVQ = 4'h4,
      I_MRMOVQ = 4'h5,
      I_OPQ    = 4'h6,
      I_JXX    = 4'h7,
      I_CALL   = 4'h8,
      I_RET    = 4'h9,
      I_PUSHQ  = 4'hA,
      I_POPQ   = 4'hB,
      I_IADDQ  = 4'hC
   } icode_type;

   typedef enum logic [1:0] {
      B_CLEAR,
      B_EXEC,
      B_LOAD
   } bstate_type;

   localparam logic [3:0] FnAdd = 4'h0;
   localparam logic [3:0] FnSub = 4'h1;
   localparam logic [3:0] FnAnd = 4'h2;
   localparam logic [3:0] FnXor = 4'h3;

   typedef struct packed {
      logic [3:0]  icode;
      logic [3:0]  ifun;
      logic [3:0]  ra;
      logic [3:0]  rb;
      logic [63:0] k;
      logic [3:0]  len;
   } decoded_type;

   function automatic logic [3:0] instr_len(logic [7:0] op, logic [3:0] ra, logic [3:0] rb);
      logic [3:0] code;
      logic [3:0] fn;
      logic [3:0] len;
      code = op[7:4];
      fn = op[3:0];
      len = 4'd0;
      case (code)
         I_HALT, I_NOP, I_RET: len = (fn == 4'd0) ? 4'd1 : 4'd0;
         I_RRMOVQ: len = (fn <= 4'd6 && ra != NoReg && rb != NoReg) ? 4'd2 : 4'd0;
         I_IRMOVQ, I_IADDQ: len = (fn == 4'd0 && ra == NoReg && rb != NoReg) ? 4'd10 : 4'd0;
         I_RMMOVQ, I_MRMOVQ:
            len = (fn == 4'd0 && ra != NoReg && rb != NoReg) ? 4'd10 : 4'd0;
         I_OPQ: len = (fn <= 4'd3 && ra != NoReg && rb != NoReg) ? 4'd2 : 4'd0;
         I_JXX: len = (fn <= 4'd6) ? 4'd9 : 4'd0;
         I_CALL: len = (fn == 4'd0) ? 4'd9 : 4'd0;
         I_PUSHQ, I_POPQ: len = (fn == 4'd0 && ra != NoReg && rb == NoReg) ? 4'd2 : 4'd0;
         default: len = 4'd0;
      endcase
      return len;
   endfunction

   function automatic logic cond_true(logic [3:0] fn, logic [2:0] cc);
      logic lt;
      logic c;
      lt = cc[1] ^ cc[2];
      case (fn)
         4'd0: c = 1'b1;
         4'd1: c = lt | cc[0];
         4'd2: c = lt;
         4'd3: c = cc[0];
         4'd4: c = ~cc[0];
         4'd5: c = ~lt;
         4'd6: c = ~lt & ~cc[0];
         default: c = 1'b0;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

/* src/y86_instruction_execute.sv */
// Accept to result passes the queue slot and the output register; loads (mrmovq,
// popq, ret) add a load state for the registered RAM read. Throughput: one
// instruction per cycle while the response is not stalled; a load holds the back end
// until its result is emitted. Reset: synchronous; after reset a clearing pass zeroes
// the data RAM while the queue fills but nothing executes.
`default_nettype none
module y86_instruction_execute #(
   parameter int MEM_BYTES = y86ie_pkg::MemBytesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_op,
   input  wire logic [7:0]  req_reg_byte,
   input  wire logic [63:0] req_const_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [63:0]      rsp_next_pc,
   output logic             rsp_zero_flag,
   output logic             rsp_sign_flag,
   output logic             rsp_overflow_flag,
   output logic [3:0]       rsp_dest_reg,
   output logic [63:0]      rsp_dest_value,
   output logic [63:0]      rsp_stack_pointer,
   output logic             rsp_mem_write,
   output logic [11:0]      rsp_mem_address,
   output logic [63:0]      rsp_mem_data
);
   logic                   q_valid;
   logic                   q_pop;
   y86ie_pkg::decoded_type q_data;

   y86ie_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_op(req_op), .req_reg_byte(req_reg_byte), .req_const_word(req_const_word),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
   );

   y86ie_back #(.MEM_BYTES(MEM_BYTES)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_next_pc(rsp_next_pc),
      .rsp_zero_flag(rsp_zero_flag), .rsp_sign_flag(rsp_sign_flag),
      .rsp_overflow_flag(rsp_overflow_flag), .rsp_dest_reg(rsp_dest_reg),
      .rsp_dest_value(rsp_dest_value), .rsp_stack_pointer(rsp_stack_pointer),
      .rsp_mem_write(rsp_mem_write), .rsp_mem_address(rsp_mem_address),
      .rsp_mem_data(rsp_mem_data)
   );
endmodule
`default_nettype wire

/* src/y86ie_ram.sv */
// Generic simple dual-port RAM (one write port, one read port) with registered read and byte-free word write.
// No dependencies.
`default_nettype none
module y86ie_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* src/y86ie_front.sv */
// Front end: accepts instructions, checks the encoding and pushes decoded
// entries into a two-entry queue. Depends on y86ie_pkg.
`default_nettype none
module y86ie_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_op,
   input  wire logic [7:0]             req_reg_byte,
   input  wire logic [63:0]            req_const_word,
   output logic                        q_valid,
   output y86ie_pkg::decoded_type      q_data,
   input  wire logic                   q_pop
);
   y86ie_pkg::decoded_type slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push;
   y86ie_pkg::decoded_type dec;

   always_comb begin
      dec.icode = req_op[7:4];
      dec.ifun  = req_op[3:0];
      dec.ra    = req_reg_byte[7:4];
      dec.rb    = req_reg_byte[3:0];
      dec.k     = req_const_word;
      dec.len   = y86ie_pkg::instr_len(req_op, req_reg_byte[7:4], req_reg_byte[3:0]);
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid & ~req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_data    = slot_ff[rd_ff];

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, q_pop};
      rd_in    = rd_ff ^ q_pop;
      wr_in    = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= dec;
      end
   end
endmodule
`default_nettype wire

/* src/y86ie_back.sv */
// Back end: executes decoded instructions against register file, flags, PC and
// eight byte-lane RAMs after a clearing pass. Depends on y86ie_pkg and y86ie_ram.
`default_nettype none
module y86ie_back #(
   parameter int MEM_BYTES = y86ie_pkg::MemBytesDefault
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  y86ie_pkg::decoded_type      q_data,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [63:0]                 rsp_next_pc,
   output logic                        rsp_zero_flag,
   output logic                        rsp_sign_flag,
   output logic                        rsp_overflow_flag,
   output logic [3:0]                  rsp_dest_reg,
   output logic [63:0]                 rsp_dest_value,
   output logic [63:0]                 rsp_stack_pointer,
   output logic                        rsp_mem_write,
   output logic [11:0]                 rsp_mem_address,
   output logic [63:0]                 rsp_mem_data
);
   localparam int Words = MEM_BYTES / 8;
   localparam int WAW = $clog2(Words);
   localparam logic [63:0] AddrMax = 64'(MEM_BYTES - 8);

   y86ie_pkg::bstate_type state_ff, state_in;
   logic [WAW:0] clr_ff, clr_in;
   logic [63:0] rf_ff [15];
   logic [2:0]  cc_ff, cc_in;
   logic [63:0] pc_ff, pc_in;
   logic [1:0]  st_ff, st_in;

   // pending load held across the RAM read
   logic [3:0]     ld_dst_ff, ld_dst_in;
   logic           ld_ret_ff, ld_ret_in;
   logic [2:0]     ld_sh_ff, ld_sh_in;
   logic [63:0]    ld_sp_ff, ld_sp_in;
   logic [WAW-1:0] ld_wi_ff, ld_wi_in;

   logic        ov_ff;
   logic [1:0]  o_st_ff;
   logic [63:0] o_pc_ff, o_dv_ff, o_sp_ff, o_md_ff;
   logic [2:0]  o_cc_ff;
   logic [3:0]  o_dr_ff;
   logic        o_mw_ff;
   logic [11:0] o_ma_ff;

   logic        out_free;
   logic        emit;
   logic [1:0]  e_st;
   logic [63:0] e_pc, e_dv, e_sp, e_md;
   logic [2:0]  e_cc;
   logic [3:0]  e_dr;
   logic        e_mw;
   logic [11:0] e_ma;

   logic        rf_we;
   logic [3:0]  rf_wa;
   logic [63:0] rf_wd;
   logic        sp_we;
   logic [63:0] sp_wd;

   // one byte lane per byte offset: any unaligned word is one access per lane
   logic [WAW-1:0] lane_addr [8];
   logic [7:0]     lane_wd [8];
   logic [7:0]     lane_rd [8];
   logic           lane_we;
   logic [WAW-1:0] lane_row;
   logic [2:0]     lane_sh;
   logic [63:0]    ld_word;

   for (genvar g = 0; g < 8; g++) begin : g_lane
      y86ie_ram #(.WIDTH(8), .DEPTH(Words)) u_lane (
         .clock(clock), .wr_en(lane_we), .wr_addr(lane_addr[g]), .wr_data(lane_wd[g]),
         .rd_addr(lane_addr[g]), .rd_data(lane_rd[g])
      );
   end

   assign out_free = ~ov_ff | ~rsp_stall;

   function automatic logic [63:0] rd_reg(input logic [63:0] rf [15], input logic [3:0] r);
      return (r == y86ie_pkg::NoReg) ? 64'd0 : rf[r];
   endfunction

   logic [63:0] va, vb, vsp, valp, ea, res, spm8;
   logic        ofl, ok, mem_op, is_load, cnd;
   logic [WAW-1:0] wi;
   logic [2:0]  sh;

   always_comb begin
      va   = rd_reg(rf_ff, q_data.ra);
      vb   = rd_reg(rf_ff, q_data.rb);
      vsp  = rf_ff[y86ie_pkg::SpReg];
      valp = pc_ff + {60'd0, q_data.len};
      spm8 = vsp - 64'd8;
      cnd  = y86ie_pkg::cond_true(q_data.ifun, cc_ff);
      res  = 64'd0;
      ofl  = 1'b0;
      ea   = 64'd0;
      ok   = 1'b1;
      mem_op  = 1'b0;
      is_load = 1'b0;
      e_st = st_ff; e_pc = pc_ff; e_cc = cc_ff; e_dr = y86ie_pkg::NoReg;
      e_dv = 64'd0; e_sp = vsp; e_mw = 1'b0; e_ma = 12'd0; e_md = 64'd0;
      rf_we = 1'b0; rf_wa = q_data.rb; rf_wd = 64'd0;
      sp_we = 1'b0; sp_wd = vsp;
      lane_we = 1'b0;
      state_in = state_ff; clr_in = clr_ff;
      st_in = st_ff; pc_in = pc_ff; cc_in = cc_ff;
      ld_dst_in = ld_dst_ff; ld_ret_in = ld_ret_ff; ld_sh_in = ld_sh_ff;
      ld_sp_in = ld_sp_ff; ld_wi_in = ld_wi_ff;
      q_pop = 1'b0;
      emit = 1'b0;

      unique case (q_data.icode)
         y86ie_pkg::I_RMMOVQ, y86ie_pkg::I_MRMOVQ: begin
            ea = vb + q_data.k; mem_op = 1'b1;
            is_load = (q_data.icode == y86ie_pkg::I_MRMOVQ);
         end
         y86ie_pkg::I_CALL, y86ie_pkg::I_PUSHQ: begin
            ea = spm8; mem_op = 1'b1;
         end
         y86ie_pkg::I_RET, y86ie_pkg::I_POPQ: begin
            ea = vsp; mem_op = 1'b1; is_load = 1'b1;
         end
         default: ea = 64'd0;
      endcase
      ok = ~mem_op | (ea <= AddrMax);
      wi = ea[WAW+2:3];
      sh = ea[2:0];
      lane_row = (state_ff == y86ie_pkg::B_LOAD) ? ld_wi_ff : wi;
      lane_sh  = (state_ff == y86ie_pkg::B_LOAD) ? ld_sh_ff : sh;
      for (int j = 0; j < 8; j++) ld_word[8*j +: 8] = lane_rd[3'(ld_sh_ff + 3'(j))];

      unique case (state_ff)
         y86ie_pkg::B_CLEAR: begin
            lane_we = 1'b1;
            clr_in = clr_ff + (WAW+1)'(1);
            if (clr_ff == (WAW+1)'(Words - 1)) state_in = y86ie_pkg::B_EXEC;
         end
         y86ie_pkg::B_EXEC: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               if (st_ff != y86ie_pkg::ST_OK) begin
                  emit = 1'b1;
               end else if (q_data.len == 4'd0) begin
                  emit = 1'b1; st_in = y86ie_pkg::ST_INS; e_st = y86ie_pkg::ST_INS;
               end else if (!ok) begin
                  emit = 1'b1; st_in = y86ie_pkg::ST_ADR; e_st = y86ie_pkg::ST_ADR;
               end else if (is_load) begin
                  state_in = y86ie_pkg::B_LOAD;
                  ld_sh_in = sh;
                  ld_wi_in = wi;
                  ld_ret_in = (q_data.icode == y86ie_pkg::I_RET);
                  ld_dst_in = q_data.ra;
                  ld_sp_in = (q_data.icode == y86ie_pkg::I_MRMOVQ) ? vsp : vsp + 64'd8;
                  pc_in = valp;
               end else begin
                  emit = 1'b1;
                  pc_in = valp;
                  unique case (q_data.icode)
                     y86ie_pkg::I_HALT: begin
                        st_in = y86ie_pkg::ST_HLT; e_st = y86ie_pkg::ST_HLT;
                     end
                     y86ie_pkg::I_RRMOVQ: begin
                        if (cnd) begin
                           e_dr = q_data.rb; e_dv = va;
                           rf_we = 1'b1; rf_wa = q_data.rb; rf_wd = va;
                        end
                     end
                     y86ie_pkg::I_IRMOVQ: begin
                        e_dr = q_data.rb; e_dv = q_data.k;
                        rf_we = 1'b1; rf_wa = q_data.rb; rf_wd = q_data.k;
                     end
                     y86ie_pkg::I_OPQ, y86ie_pkg::I_IADDQ: begin
                        if (q_data.icode == y86ie_pkg::I_IADDQ) va = q_data.k;
                        case (q_data.ifun)
                           y86ie_pkg::FnAdd: begin
                              res = vb + va; ofl = ~(va[63] ^ vb[63]) & (va[63] ^ res[63]);
                           end
                           y86ie_pkg::FnSub: begin
                              res = vb - va; ofl = (va[63] ^ vb[63]) & (vb[63] ^ res[63]);
                           end
                           y86ie_pkg::FnAnd: res = vb & va;
                           default: res = vb ^ va;
                        endcase
                        cc_in = {ofl, res[63], res == 64'd0};
                        e_dr = q_data.rb; e_dv = res;
                        rf_we = 1'b1; rf_wa = q_data.rb; rf_wd = res;
                     end
                     y86ie_pkg::I_JXX: begin
                        if (cnd) pc_in = q_data.k;
                     end
                     y86ie_pkg::I_RMMOVQ, y86ie_pkg::I_CALL, y86ie_pkg::I_PUSHQ: begin
                        e_mw = 1'b1; e_ma = ea[11:0];
                        e_md = (q_data.icode == y86ie_pkg::I_CALL) ? valp : va;
                        if (q_data.icode != y86ie_pkg::I_RMMOVQ) begin
                           sp_we = 1'b1; sp_wd = spm8;
                        end
                        if (q_data.icode == y86ie_pkg::I_CALL) pc_in = q_data.k;
                        lane_we = 1'b1;
                     end
                     default: begin
                     end
                  endcase
                  e_pc = pc_in; e_cc = cc_in;
                  e_sp = sp_we ? sp_wd : ((rf_we && rf_wa == y86ie_pkg::SpReg) ? rf_wd : vsp);
               end
            end
         end
         y86ie_pkg::B_LOAD: begin
            if (out_free) begin
               emit = 1'b1;
               state_in = y86ie_pkg::B_EXEC;
               sp_we = ld_ret_ff | (ld_dst_ff != y86ie_pkg::SpReg);
               sp_wd = ld_sp_ff;
               if (ld_ret_ff) begin
                  pc_in = ld_word;
               end else begin
                  rf_we = 1'b1; rf_wa = ld_dst_ff; rf_wd = ld_word;
                  e_dr = ld_dst_ff; e_dv = ld_word;
               end
               e_pc = pc_in;
               e_sp = (rf_we && rf_wa == y86ie_pkg::SpReg) ? rf_wd : ld_sp_ff;
            end
         end
         default: state_in = y86ie_pkg::B_CLEAR;
      endcase

      for (int i = 0; i < 8; i++) begin
         lane_addr[i] = (3'(i) < lane_sh) ? lane_row + WAW'(1) : lane_row;
         lane_wd[i]   = e_md[{3'(i) - sh, 3'b000} +: 8];
      end
      if (state_ff == y86ie_pkg::B_CLEAR) begin
         for (int i = 0; i < 8; i++) begin
            lane_addr[i] = clr_ff[WAW-1:0];
            lane_wd[i]   = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= y86ie_pkg::B_CLEAR;
         clr_ff   <= '0;
         st_ff    <= y86ie_pkg::ST_OK;
         pc_ff    <= 64'd0;
         cc_ff    <= 3'd0;
         ov_ff    <= 1'b0;
         for (int i = 0; i < 15; i++) rf_ff[i] <= 64'd0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         st_ff    <= st_in;
         pc_ff    <= pc_in;
         cc_ff    <= cc_in;
         if (sp_we) rf_ff[y86ie_pkg::SpReg] <= sp_wd;
         if (rf_we && rf_wa != y86ie_pkg::NoReg) rf_ff[rf_wa] <= rf_wd;
         if (emit) ov_ff <= 1'b1;
         else if (!rsp_stall) ov_ff <= 1'b0;
      end
      ld_dst_ff <= ld_dst_in; ld_ret_ff <= ld_ret_in; ld_sh_ff <= ld_sh_in;
      ld_sp_ff <= ld_sp_in; ld_wi_ff <= ld_wi_in;
      if (emit) begin
         o_st_ff <= e_st; o_pc_ff <= e_pc; o_cc_ff <= e_cc; o_dr_ff <= e_dr;
         o_dv_ff <= e_dv; o_sp_ff <= e_sp; o_mw_ff <= e_mw; o_ma_ff <= e_ma;
         o_md_ff <= e_md;
      end
   end

   assign rsp_valid         = ov_ff;
   assign rsp_status        = o_st_ff;
   assign rsp_next_pc       = o_pc_ff;
   assign rsp_zero_flag     = o_cc_ff[0];
   assign rsp_sign_flag     = o_cc_ff[1];
   assign rsp_overflow_flag = o_cc_ff[2];
   assign rsp_dest_reg      = o_dr_ff;
   assign rsp_dest_value    = o_dv_ff;
   assign rsp_stack_pointer = o_sp_ff;
   assign rsp_mem_write     = o_mw_ff;
   assign rsp_mem_address   = o_ma_ff;
   assign rsp_mem_data      = o_md_ff;
endmodule
`default_nettype wire

/* src/y86ie_checker.sv */
// Port-level checker for the Y86-64 executor, bound to the top level.
// Depends on y86ie_pkg.
`default_nettype none
module y86ie_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic [63:0] rsp_next_pc,
   input wire logic [3:0]  rsp_dest_reg,
   input wire logic        rsp_mem_write
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_next_pc))
      else $error("stalled result changed");

   a_stop_no_store: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != y86ie_pkg::ST_OK |-> !rsp_mem_write)
      else $error("store on stopped machine");

   a_err_no_dest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == y86ie_pkg::ST_ADR || rsp_status == y86ie_pkg::ST_INS)
      |-> rsp_dest_reg == y86ie_pkg::NoReg)
      else $error("register write on error");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
endmodule

bind y86_instruction_execute y86ie_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_status(rsp_status), .rsp_next_pc(rsp_next_pc),
   .rsp_dest_reg(rsp_dest_reg), .rsp_mem_write(rsp_mem_write)
);
`default_nettype wire
